FILE: rtl/core/tmc_pkg.sv
package tmc_pkg;

  localparam int unsigned InW    = 168;  // packed input fields
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumW   = 57;   // widest dividend
  localparam int unsigned DenW   = 32;
  localparam int unsigned QuoW   = 33;   // quotient bits, one per restoring stage
  localparam int unsigned NLanes = 2;    // position, area

  localparam logic [RegIdxW-1:0] REG_POS_WEIGHT   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MEAN_DIAM    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_AREA_WEIGHT  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_SHAPE_WEIGHT = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ANGLE_WEIGHT = 3'd4;

  localparam logic [15:0] RST_POS_WEIGHT   = 16'd256;
  localparam logic [15:0] RST_MEAN_DIAM    = 16'd160;
  localparam logic [15:0] RST_AREA_WEIGHT  = 16'd256;
  localparam logic [15:0] RST_SHAPE_WEIGHT = 16'd256;
  localparam logic [15:0] RST_ANGLE_WEIGHT = 16'd256;

  localparam logic [16:0] DEG90  = 17'd23040;   // Q8.8
  localparam logic [16:0] DEG180 = 17'd46080;
  localparam logic [DenW-1:0] ANGLE_DEN = 32'd11796480;  // 180 * 65536
  // ceil(2^36 / 45), exact for dividends below 2^30
  localparam logic [30:0] ANGLE_RECIP = 31'd1527099484;
  localparam logic [33:0] TERM_CAP = 34'h1_0000_0000;
  localparam logic [35:0] COST_MAX = 36'h0_FFFF_FFFF;

endpackage

FILE: rtl/core/track_match_cost.sv
// matching cost of one object/trajectory pair per beat. the pipeline takes a
// new beat every cycle and passes it through four stages of
// differences and products (the angle term divides by 180 * 65536 there as a
// shift and a reciprocal multiply by 1/45), then 34 divider stages, one load
// stage and 33 restoring stages that resolve one quotient bit each, in two
// lanes (position, area), then one stage that caps each term, sums them and
// clips to the Q16.16 max. a stall at the output holds the whole pipeline.
module track_match_cost (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // object_x, object_y, object_area, object_ecc, object_angle, traj_centroid_x,
  // traj_centroid_y, traj_area, traj_ecc, traj_angle
  input  logic [tmc_pkg::InW-1:0]       s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cost
  output logic [31:0]                   m_tdata,
  // saturated
  output logic [0:0]                    m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmc_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [15:0]                   cfg_data
);
  import tmc_pkg::*;

  logic [15:0] position_weight, mean_diameter, area_weight, shape_weight, angle_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_weight <= RST_POS_WEIGHT;
      mean_diameter   <= RST_MEAN_DIAM;
      area_weight     <= RST_AREA_WEIGHT;
      shape_weight    <= RST_SHAPE_WEIGHT;
      angle_weight    <= RST_ANGLE_WEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_WEIGHT:   position_weight <= cfg_data;
        REG_MEAN_DIAM:    mean_diameter   <= cfg_data;
        REG_AREA_WEIGHT:  area_weight     <= cfg_data;
        REG_SHAPE_WEIGHT: shape_weight    <= cfg_data;
        REG_ANGLE_WEIGHT: angle_weight    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: differences, sums, folded angle, diameter squared
  logic        s1_v;
  logic [15:0] s1_dx, s1_dy, s1_ediff, s1_fold;
  logic [19:0] s1_adiff;
  logic [20:0] s1_asum;
  logic [16:0] s1_esum;
  logic [31:0] s1_dsq;

  logic [15:0] ox, oy, oe, tx, ty, te, diam;
  logic [19:0] oa, ta;
  logic signed [16:0] dang;
  logic [16:0] dmag;
  logic [15:0] fold;

  always_comb begin
    ox   = s_tdata[15:0];
    oy   = s_tdata[31:16];
    oa   = s_tdata[51:32];
    oe   = s_tdata[67:52];
    tx   = s_tdata[99:84];
    ty   = s_tdata[115:100];
    ta   = s_tdata[135:116];
    te   = s_tdata[151:136];
    dang = signed'({s_tdata[83], s_tdata[83:68]}) - signed'({s_tdata[167], s_tdata[167:152]});
    dmag = dang[16] ? 17'(-dang) : 17'(dang);
    if (dmag < DEG90) begin
      fold = dmag[15:0];
    end else if (dmag <= DEG180) begin
      fold = 16'(DEG180 - dmag);
    end else begin
      fold = '0;
    end
    diam = (mean_diameter == '0) ? 16'd1 : mean_diameter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx    <= (ox > tx) ? ox - tx : tx - ox;
      s1_dy    <= (oy > ty) ? oy - ty : ty - oy;
      s1_adiff <= (oa > ta) ? oa - ta : ta - oa;
      s1_asum  <= {1'b0, oa} + {1'b0, ta};
      s1_ediff <= (oe > te) ? oe - te : te - oe;
      s1_esum  <= {1'b0, oe} + {1'b0, te};
      s1_fold  <= fold;
      s1_dsq   <= diam * diam;
    end
  end

  // stage 2: products
  logic        s2_v;
  logic [31:0] s2_dx2, s2_dy2, s2_sprod, s2_dsq;
  logic [35:0] s2_bprod;
  logic [32:0] s2_gprod;
  logic [20:0] s2_asum;
  logic [15:0] s2_fold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx2   <= s1_dx * s1_dx;
      s2_dy2   <= s1_dy * s1_dy;
      s2_bprod <= area_weight * s1_adiff;
      s2_sprod <= shape_weight * s1_ediff;
      s2_gprod <= angle_weight * s1_esum;
      s2_asum  <= s1_asum;
      s2_fold  <= s1_fold;
      s2_dsq   <= s1_dsq;
    end
  end

  // stage 3
  logic        s3_v;
  logic [32:0] s3_d2;
  logic [23:0] s3_shape;
  logic [48:0] s3_aprod;
  logic [35:0] s3_bprod;
  logic [20:0] s3_asum;
  logic [31:0] s3_dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2    <= {1'b0, s2_dx2} + {1'b0, s2_dy2};
      s3_shape <= s2_sprod[31:8];
      s3_aprod <= s2_gprod * s2_fold;
      s3_bprod <= s2_bprod;
      s3_asum  <= s2_asum;
      s3_dsq   <= s2_dsq;
    end
  end

  // stage 4: angle product stays below 2^48, so x / (180 * 65536) is
  // (x >> 18) / 45 on a 30-bit value
  logic        s4_v;
  logic [48:0] s4_pprod;
  logic [24:0] s4_ang;
  logic [23:0] s4_shape;
  logic [35:0] s4_bprod;
  logic [20:0] s4_asum;
  logic [31:0] s4_dsq;
  logic [60:0] ang_mul;

  assign ang_mul = s3_aprod[47:18] * ANGLE_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pprod <= position_weight * s3_d2;
      s4_ang   <= ang_mul[60:36];
      s4_shape <= s3_shape;
      s4_bprod <= s3_bprod;
      s4_asum  <= s3_asum;
      s4_dsq   <= s3_dsq;
    end
  end

  // divider entry: lane 0 position, lane 1 area
  logic [NumW-1:0] num [NLanes];
  logic [DenW-1:0] den [NLanes];

  always_comb begin
    num[0] = {s4_pprod, 8'b0};
    num[1] = NumW'({s4_bprod, 9'b0});
    den[0] = s4_dsq;
    // both areas zero gives a zero dividend, so any nonzero divisor yields zero
    den[1] = (s4_asum == '0) ? 32'd1 : DenW'(s4_asum);
  end

  logic            dv  [0:QuoW];
  logic [25:0]     dsh [0:QuoW];  // shape plus angle terms
  logic [DenW-1:0] dr  [0:QuoW][NLanes];
  logic [QuoW-1:0] dn  [0:QuoW][NLanes];
  logic [QuoW-1:0] dq  [0:QuoW][NLanes];
  logic [DenW-1:0] dd  [0:QuoW][NLanes];
  logic            dof [0:QuoW][NLanes];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsh[0] <= 26'(s4_shape) + 26'(s4_ang);
      for (int l = 0; l < NLanes; l++) begin
        // quotient would need more than QuoW bits
        dof[0][l] <= {8'b0, num[l][NumW-1:QuoW]} >= den[l];
        dr[0][l]  <= {8'b0, num[l][NumW-1:QuoW]};
        dn[0][l]  <= num[l][QuoW-1:0];
        dq[0][l]  <= '0;
        dd[0][l]  <= den[l];
      end
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    logic [DenW:0] trial [NLanes];
    logic          ge    [NLanes];

    always_comb begin
      for (int l = 0; l < NLanes; l++) begin
        trial[l] = {dr[k-1][l], dn[k-1][l][QuoW-1]};
        ge[l]    = trial[l] >= {1'b0, dd[k-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsh[k] <= dsh[k-1];
        for (int l = 0; l < NLanes; l++) begin
          dr[k][l]  <= ge[l] ? DenW'(trial[l] - {1'b0, dd[k-1][l]}) : trial[l][DenW-1:0];
          dn[k][l]  <= {dn[k-1][l][QuoW-2:0], 1'b0};
          dq[k][l]  <= {dq[k-1][l][QuoW-2:0], ge[l]};
          dd[k][l]  <= dd[k-1][l];
          dof[k][l] <= dof[k-1][l];
        end
      end
    end
  end

  // final: cap each term, add, clip
  logic [33:0] term [NLanes];
  logic [35:0] total;

  always_comb begin
    for (int l = 0; l < NLanes; l++) begin
      if (dof[QuoW][l] || {1'b0, dq[QuoW][l]} > TERM_CAP) begin
        term[l] = TERM_CAP;
      end else begin
        term[l] = {1'b0, dq[QuoW][l]};
      end
    end
    total = 36'(term[0]) + 36'(term[1]) + 36'(dsh[QuoW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (total > COST_MAX) begin
        m_tdata <= 32'hFFFF_FFFF;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= total[31:0];
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/sv/tb_track_match_cost.sv
module tb_track_match_cost;
  timeunit 1ns;
  timeprecision 1ps;
  import tmc_pkg::*;

  localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [15:0] t_ang;
    logic [15:0] t_ecc;
    logic [19:0] t_area;
    logic [15:0] t_y;
    logic [15:0] t_x;
    logic signed [15:0] o_ang;
    logic [15:0] o_ecc;
    logic [19:0] o_area;
    logic [15:0] o_y;
    logic [15:0] o_x;
  } pair_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] cost;
  } cost_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [InW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  track_match_cost dut (.*);

  always #10 clk = ~clk;

  logic [15:0] w_pos, w_diam, w_area, w_shape, w_ang;
  cost_t cost_q[$];
  int n_sent, n_got, n_bad;
  bit hold_long, no_idle;

  function automatic logic [63:0] absd(logic [63:0] a, logic [63:0] b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic cost_t match_cost(pair_t p);
    logic [63:0] diam, d2, pos, asum, area, shape, d, fold, ang, total;
    int signed dang;
    cost_t r;
    diam = (w_diam == 0) ? 64'd1 : 64'(w_diam);
    d2 = absd(64'(p.o_x), 64'(p.t_x)) ** 2 + absd(64'(p.o_y), 64'(p.t_y)) ** 2;
    pos = (64'(w_pos) * d2 * 256) / (diam * diam);
    if (pos > 64'h1_0000_0000) pos = 64'h1_0000_0000;
    asum = 64'(p.o_area) + 64'(p.t_area);
    area = '0;
    if (asum != 0) area = (64'(w_area) * absd(64'(p.o_area), 64'(p.t_area)) * 512) / asum;
    shape = (64'(w_shape) * absd(64'(p.o_ecc), 64'(p.t_ecc))) >> 8;
    dang = int'(p.o_ang) - int'(p.t_ang);
    d = 64'(dang < 0 ? -dang : dang);
    if (d < 23040) fold = d;
    else if (d <= 46080) fold = 46080 - d;
    else fold = '0;
    ang = (64'(w_ang) * (64'(p.o_ecc) + 64'(p.t_ecc)) * fold) / 64'(ANGLE_DEN);
    total = pos + area + shape + ang;
    r.sat = total > 64'hFFFF_FFFF;
    r.cost = r.sat ? 32'hFFFF_FFFF : total[31:0];
    return r;
  endfunction

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [15:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_POS_WEIGHT:   w_pos = val;
      REG_MEAN_DIAM:    w_diam = val;
      REG_AREA_WEIGHT:  w_area = val;
      REG_SHAPE_WEIGHT: w_shape = val;
      REG_ANGLE_WEIGHT: w_ang = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    int t;
    t = 0;
    while (cost_q.size() != 0 && t < 200000) begin
      @(posedge clk); t++;
    end
    repeat (50) @(posedge clk);
  endtask

  // one beat on the slave side; checked against the predictor unless a typed value is given
  task automatic send(pair_t p, bit typed = 0, cost_t want = '0);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= p;
    cost_q.push_back(typed ? want : match_cost(p));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  function automatic pair_t rand_pair(int mode);
    pair_t p;
    p = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode != 0) begin
      p.o_ang = 16'($signed($urandom_range(0, 46080)) - 23040);
      p.t_ang = 16'($signed($urandom_range(0, 46080)) - 23040);
    end
    if (mode == 2) begin
      p.t_x = p.o_x + 16'($urandom_range(0, 511)) - 16'd256;
      p.t_y = p.o_y + 16'($urandom_range(0, 511)) - 16'd256;
      p.o_area = 20'($urandom_range(0, 4000));
      p.t_area = 20'($urandom_range(0, 4000));
    end
    return p;
  endfunction

  // master side: random stalls, plus one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      if (hold_long) begin
        m_tready <= 0;
        repeat (200) @(posedge clk);
        hold_long = 0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      cost_t w;
      n_got++;
      if (cost_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat cost=%h sat=%b", m_tdata, m_tuser);
      end else begin
        w = cost_q.pop_front();
        if (w.cost !== m_tdata || w.sat !== m_tuser[0]) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected cost=%h sat=%b, got cost=%h sat=%b",
                     w.cost, w.sat, m_tdata, m_tuser);
        end
      end
    end
  end

  pair_t dir_tab[16];
  bit    dir_typed[16];
  cost_t dir_want[16];

  initial begin
    pair_t p;
    w_pos = RST_POS_WEIGHT; w_diam = RST_MEAN_DIAM; w_area = RST_AREA_WEIGHT;
    w_shape = RST_SHAPE_WEIGHT; w_ang = RST_ANGLE_WEIGHT;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows
    dir_tab[0] = '0; dir_typed[0] = 1; dir_want[0] = '0;       // identical, zero areas
    p = '0; p.o_x = 16'd160; dir_tab[1] = p;                    // dx of one diameter
    dir_typed[1] = 1; dir_want[1] = '{sat: 0, cost: 32'h0001_0000};
    p = '0; p.o_area = 20'd10; dir_tab[2] = p;                   // one area zero
    dir_typed[2] = 1; dir_want[2] = '{sat: 0, cost: 32'h0002_0000};
    p = '0; p.o_x = 16'hFFFF; p.o_y = 16'hFFFF; dir_tab[3] = p;  // far apart: clip
    dir_typed[3] = 1; dir_want[3] = '{sat: 1, cost: 32'hFFFF_FFFF};
    p = '0; p.o_ecc = 16'hFFFF; dir_tab[4] = p;
    p = '0; p.o_ecc = 16'hFFFF; p.t_ecc = 16'hFFFF; p.o_ang = 16'sd23040;
    p.t_ang = -16'sd23040; dir_tab[5] = p;                       // 180 deg folds to zero
    p.o_ang = 16'sd23040; p.t_ang = 16'sd0; dir_tab[6] = p;      // exactly 90
    p.o_ang = 16'h7FFF; p.t_ang = 16'h8000; dir_tab[7] = p;      // beyond 180: fold zero
    p.o_ang = 16'sd100; p.t_ang = -16'sd100; dir_tab[8] = p;
    p = '0; p.o_area = 20'hFFFFF; p.t_area = 20'hFFFFF; dir_tab[9] = p;
    p = '0; p.o_area = 20'hFFFFF; p.t_area = 20'd1; dir_tab[10] = p;
    p = '1; dir_tab[11] = p;
    p = '0; p.t_x = 16'hFFFF; p.t_y = 16'h1; dir_tab[12] = p;
    for (int i = 13; i < 16; i++) dir_tab[i] = rand_pair(1);
    for (int i = 4; i < 16; i++) dir_typed[i] = 0;
    for (int i = 0; i < 16; i++) send(dir_tab[i], dir_typed[i], dir_want[i]);
    s_tvalid <= 0;
    drain();

    // settings phases, extremes included; each phase writes every register
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_POS_WEIGHT, 16'hFFFF); write_reg(REG_MEAN_DIAM, 16'd0); end
        1: begin write_reg(REG_POS_WEIGHT, 16'd0); write_reg(REG_MEAN_DIAM, 16'hFFFF); end
        default: begin
          write_reg(REG_POS_WEIGHT, 16'($urandom)); write_reg(REG_MEAN_DIAM, 16'($urandom));
        end
      endcase
      write_reg(REG_AREA_WEIGHT, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : 16'($urandom));
      write_reg(REG_SHAPE_WEIGHT, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : 16'($urandom));
      write_reg(REG_ANGLE_WEIGHT, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : 16'($urandom));
      if (ph == 2) write_reg(REG_UNUSED, 16'h1234);  // index off the list, ignored
      if (ph == 5) no_idle = 1;
      for (int i = 0; i < 330; i++) begin
        if (ph == 3 && i == 10) hold_long = 1;
        send(rand_pair($urandom_range(0, 9) < 1 ? 0 : ($urandom_range(0, 1) + 1)));
      end
      s_tvalid <= 0;
      drain();
    end

    if (cost_q.size() != 0) begin
      n_bad++;
      $display("%0d expected beats never arrived", cost_q.size());
    end
    $display("sent %0d pairs over seven register settings, received %0d costs", n_sent, n_got);
    $display("%0d mismatches", n_bad);
    if (n_bad == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
